// ===== design/adcf_pkg.sv =====
// Package for the distortion waveshaper: constants, register codes and sequencer states.
package adcf_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int LEN_W      = 9;
	localparam int ADDR_W     = 4;
	localparam int BLOCK_MAX  = 256;
	localparam int DIV_STEPS  = 31;
	localparam int CNT_W      = 5;
	localparam int MUL_A_W    = 33;
	localparam int MUL_B_W    = 18;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 16;

	localparam logic [15:0]      MIX_ONE     = 16'd32768;
	localparam logic [15:0]      DRIVE_MAX   = 16'd65535;
	localparam logic [14:0]      FOLD_OFFSET = 15'd24576;
	localparam logic [LEN_W-1:0] LEN_RESET   = 9'd64;

	typedef enum logic [1:0] {
		REG_ENABLE       = 2'd0,
		REG_SHAPE_MODE   = 2'd1,
		REG_BLOCK_LENGTH = 2'd2,
		REG_NONE         = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_DRV,
		ST_DIV_MIX,
		ST_MUL_DRV,
		ST_MUL_MIX,
		ST_MUL_T,
		ST_SHAPE,
		ST_MUL_Y,
		ST_FIN
	} state_t;

endpackage

// ===== design/audio_distortion_clip_fold.sv =====
// Distortion waveshaper with ramped drive and mix: hard clip or triangle fold.
//
// Input stream (s_t*): one request carries a Q1.15 sample and the drive and mix targets
// for the current control block. Targets are taken only at the first sample of a block.
// Output stream (m_t*): one processed Q1.15 sample per request, in order.
// APB port: enable at 0x0, shape_mode at 0x4, block_length at 0x8; write only when idle.
//
// One request is worked through a sequencer around a single 33x18 multiplier, one
// product per cycle, registered before use. Inside a block a request passes through
// ST_MUL_DRV, ST_MUL_MIX, ST_MUL_T, ST_SHAPE, ST_MUL_Y and ST_FIN to the output
// register; the next request is accepted once the sequencer is back in ST_IDLE. At the
// first sample of a block the two ramp steps are first found by a shared restoring
// divider, one quotient bit per cycle, in ST_DIV_DRV and then ST_DIV_MIX. With
// distortion disabled the sample goes straight to ST_FIN and then the output register,
// and the ramp state is left untouched. s_tready is high only while the sequencer is
// idle, so a new request is taken only after the last one is finished.
// The output register lets the next request be accepted while a result waits; if the
// receiver stalls, the sequencer holds its finished result until the register frees.
// Reset clears enable, shape_mode, ramp state and position; block_length returns to 64.
module audio_distortion_clip_fold (
	input  logic                           clk,
	input  logic                           arst_n,
	// APB configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [adcf_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	// input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [adcf_pkg::IN_DATA_W-1:0] s_tdata,  // sample_in, drive_target, mix_target
	// output stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [adcf_pkg::OUT_DATA_W-1:0] m_tdata  // sample_out
);
	import adcf_pkg::*;

	// configuration
	logic             enable_q;
	logic             shape_mode_q;
	logic [LEN_W-1:0] block_length_q;
	reg_idx_t         cfg_idx;
	logic             cfg_wr;

	// ramp state
	logic [15:0]        drive_prev_q, mix_prev_q, drive_next_q, mix_next_q;
	logic signed [31:0] drive_step_q, mix_step_q;
	logic [LEN_W-1:0]   pos_q;

	// per request
	state_t state_q, state_d;
	logic signed [SAMPLE_W-1:0] x_q;
	logic        en_q;
	logic [15:0] drive_q, mix_q;
	logic signed [17:0] diff_q;

	// divider
	logic [30:0]      dvd_q;
	logic [7:0]       rem_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;

	// multiplier
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p, prod_q;

	// output register
	logic                      m_tvalid_q;
	logic [OUT_DATA_W-1:0]     m_tdata_q;

	logic             s_acc, out_free, div_last;
	logic [LEN_W-1:0] len_eff;
	logic [SAMPLE_W-1:0] in_sample, in_drive, in_mix, mix_sat;
	logic signed [16:0] in_drv_diff, mix_diff;
	logic [8:0]  trial;
	logic        q_bit;
	logic [7:0]  rem_nx;
	logic [30:0] quo_nx;
	logic signed [31:0] step_res;
	logic signed [36:0] ramp_sum;
	logic [15:0] ramp_drive, ramp_mix;
	logic signed [24:0] t_val;
	logic [14:0] fold_r;
	logic signed [17:0] fold_d, wet;
	logic signed [20:0] y_sum;
	logic signed [SAMPLE_W-1:0] y_sat;
	logic [LEN_W:0] pos_inc;

	function automatic logic [15:0] mag16(input logic signed [16:0] d);
		logic signed [16:0] n;
		n = -d;
		return d[16] ? n[15:0] : d[15:0];
	endfunction

	// ---------------- APB ----------------
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_ENABLE:       prdata = {31'b0, enable_q};
			REG_SHAPE_MODE:   prdata = {31'b0, shape_mode_q};
			REG_BLOCK_LENGTH: prdata = {23'b0, block_length_q};
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q       <= 1'b0;
			shape_mode_q   <= 1'b0;
			block_length_q <= LEN_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_ENABLE:       enable_q       <= pwdata[0];
				REG_SHAPE_MODE:   shape_mode_q   <= pwdata[0];
				REG_BLOCK_LENGTH: block_length_q <= pwdata[LEN_W-1:0];
				default:          ;
			endcase
		end
	end

	// Zero length acts as one, anything above the maximum as the maximum.
	always_comb begin
		if (block_length_q == '0)
			len_eff = LEN_W'(1);
		else if (block_length_q > LEN_W'(BLOCK_MAX))
			len_eff = LEN_W'(BLOCK_MAX);
		else
			len_eff = block_length_q;
	end

	// ---------------- input decode ----------------
	assign in_sample = s_tdata[15:0];
	assign in_drive  = s_tdata[31:16];
	assign in_mix    = s_tdata[47:32];
	assign mix_sat   = (in_mix > MIX_ONE) ? MIX_ONE : in_mix;
	assign in_drv_diff = $signed({1'b0, in_drive}) - $signed({1'b0, drive_prev_q});
	assign mix_diff    = $signed({1'b0, mix_next_q}) - $signed({1'b0, mix_prev_q});

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid & s_tready;
	assign out_free = ~m_tvalid_q | m_tready;

	// ---------------- restoring divider step ----------------
	assign trial    = {rem_q, dvd_q[30]};
	assign q_bit    = (trial >= len_eff);
	assign rem_nx   = q_bit ? 8'(trial - len_eff) : trial[7:0];
	assign quo_nx   = {dvd_q[29:0], q_bit};
	assign div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign step_res = neg_q ? -$signed({1'b0, quo_nx}) : $signed({1'b0, quo_nx});

	// ---------------- shared multiplier ----------------
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MUL_DRV: begin
				mul_a = MUL_A_W'(drive_step_q);
				mul_b = $signed({(MUL_B_W-LEN_W)'(0), pos_q});
			end
			ST_MUL_MIX: begin
				mul_a = MUL_A_W'(mix_step_q);
				mul_b = $signed({(MUL_B_W-LEN_W)'(0), pos_q});
			end
			ST_MUL_T: begin
				mul_a = $signed({17'b0, drive_q});
				mul_b = MUL_B_W'(x_q);
			end
			ST_MUL_Y: begin
				mul_a = MUL_A_W'(diff_q);
				mul_b = $signed({2'b0, mix_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Ramp value: previous value plus the floored product of position and step.
	// The product waiting in prod_q belongs to drive in ST_MUL_MIX, to mix in ST_MUL_T.
	always_comb begin
		ramp_sum = (state_q == ST_MUL_MIX) ? $signed({21'b0, drive_prev_q})
		                                   : $signed({21'b0, mix_prev_q});
		ramp_sum = ramp_sum + $signed({prod_q[PROD_W-1], prod_q[PROD_W-1:15]});
		if (ramp_sum < 0)
			ramp_drive = '0;
		else if (ramp_sum > $signed({21'b0, DRIVE_MAX}))
			ramp_drive = DRIVE_MAX;
		else
			ramp_drive = ramp_sum[15:0];
		if (ramp_sum < 0)
			ramp_mix = '0;
		else if (ramp_sum > $signed({21'b0, MIX_ONE}))
			ramp_mix = MIX_ONE;
		else
			ramp_mix = ramp_sum[15:0];
	end

	// Shaper: t is drive * x floored by 8 bits.
	assign t_val  = prod_q[32:8];
	assign fold_r = prod_q[24:10] + FOLD_OFFSET;
	assign fold_d = 18'sd65536 - $signed({1'b0, fold_r, 2'b00});

	always_comb begin
		if (shape_mode_q) begin
			wet = (fold_d[17] ? -fold_d : fold_d) - 18'sd32768;
		end else begin
			priority if (t_val > 25'sd32768)
				wet = 18'sd32768;
			else if (t_val < -25'sd32768)
				wet = -18'sd32768;
			else
				wet = t_val[17:0];
		end
	end

	// Blend and saturate.
	always_comb begin
		y_sum = 21'(x_q) + $signed(prod_q[35:15]);
		if (y_sum > 21'sd32767)
			y_sat = 16'sh7fff;
		else if (y_sum < -21'sd32768)
			y_sat = 16'sh8000;
		else
			y_sat = y_sum[15:0];
	end

	assign pos_inc = {1'b0, pos_q} + (LEN_W+1)'(1);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					if (!enable_q)
						state_d = ST_FIN;
					else if (pos_q == '0)
						state_d = ST_DIV_DRV;
					else
						state_d = ST_MUL_DRV;
				end
			end
			ST_DIV_DRV: if (div_last) state_d = ST_DIV_MIX;
			ST_DIV_MIX: if (div_last) state_d = ST_MUL_DRV;
			ST_MUL_DRV: state_d = ST_MUL_MIX;
			ST_MUL_MIX: state_d = ST_MUL_T;
			ST_MUL_T:   state_d = ST_SHAPE;
			ST_SHAPE:   state_d = ST_MUL_Y;
			ST_MUL_Y:   state_d = ST_FIN;
			ST_FIN:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// ---------------- payload path ----------------
	always_ff @(posedge clk) begin
		// hold the blend product while the finished result waits
		if (state_q != ST_FIN)
			prod_q <= mul_p;
		unique case (state_q)
			ST_IDLE: begin
				x_q  <= $signed(in_sample);
				en_q <= enable_q;
				// start the drive step division at a block start
				dvd_q <= {mag16(in_drv_diff), 15'b0};
				neg_q <= in_drv_diff[16];
				rem_q <= '0;
				cnt_q <= '0;
			end
			ST_DIV_DRV, ST_DIV_MIX: begin
				if (div_last) begin
					// reload for the mix step
					dvd_q <= {mag16(mix_diff), 15'b0};
					neg_q <= mix_diff[16];
					rem_q <= '0;
					cnt_q <= '0;
				end else begin
					dvd_q <= quo_nx;
					rem_q <= rem_nx;
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			ST_MUL_MIX: drive_q <= ramp_drive;
			ST_MUL_T:   mix_q   <= ramp_mix;
			ST_SHAPE:   diff_q  <= wet - 18'(x_q);
			default:    ;
		endcase
	end

	// ---------------- ramp state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_prev_q <= '0;
			mix_prev_q   <= '0;
			drive_next_q <= '0;
			mix_next_q   <= '0;
			drive_step_q <= '0;
			mix_step_q   <= '0;
			pos_q        <= '0;
		end else begin
			if (s_acc && enable_q && pos_q == '0) begin
				drive_next_q <= in_drive;
				mix_next_q   <= mix_sat;
			end
			if (state_q == ST_DIV_DRV && div_last)
				drive_step_q <= step_res;
			if (state_q == ST_DIV_MIX && div_last)
				mix_step_q <= step_res;
			// advance the position once the result is handed over
			if (state_q == ST_FIN && out_free && en_q) begin
				if (pos_inc >= {1'b0, len_eff}) begin
					pos_q        <= '0;
					drive_prev_q <= drive_next_q;
					mix_prev_q   <= mix_next_q;
				end else begin
					pos_q <= pos_inc[LEN_W-1:0];
				end
			end
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free)
			m_tdata_q <= en_q ? y_sat : x_q;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== design/adcf_checker.sv =====
// Port-level checker for the distortion waveshaper, bound to the top level.
module adcf_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic [31:0]                      prdata,
	input logic                             pready,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [adcf_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import adcf_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output changed");

	// one request at a time: busy right after acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");

	// a new result only appears from the busy sequencer
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without a request in flight");

	// read data carries no bits beyond the widest register
	a_prdata_width: assert property (@(posedge clk) disable iff (!arst_n)
		pready && prdata[31:LEN_W] == '0)
		else $error("bad APB read data");

endmodule

bind audio_distortion_clip_fold adcf_checker u_adcf_checker (.*);
